// ===== hdl/ladsr_pkg.sv =====
// Shared constants, types and codes for the linear ADSR envelope block.
`timescale 1ns / 1ps
`default_nettype none

package ladsr_pkg;

    localparam int COUNT_WIDTH  = 24;
    localparam int SAMPLE_WIDTH = 24;

    localparam int LEN_W   = 24;
    localparam int LVL_W   = 17;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 24;
    localparam int FRAC_W  = 16;
    localparam int GAIN_W  = 17;
    localparam int QUO_W   = 17;
    localparam int DVD_W   = LEN_W + QUO_W;
    localparam int DCNT_W  = $clog2(QUO_W + 1);
    localparam int BND_W   = LEN_W + 2;
    localparam int CMP_W   = ((COUNT_WIDTH > BND_W) ? COUNT_WIDTH : BND_W) + 1;
    localparam int MUL_A_W = ((SAMPLE_WIDTH > LEN_W) ? SAMPLE_WIDTH : LEN_W) + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SH_W    = PROD_W - FRAC_W;

    localparam logic [GAIN_W-1:0] UNITY = 17'h10000;

    localparam logic [LEN_W-1:0] ATTACK_RST  = 24'd4410;
    localparam logic [LEN_W-1:0] DECAY_RST   = 24'd13230;
    localparam logic [LEN_W-1:0] SUSTAIN_RST = 24'd22050;
    localparam logic [LEN_W-1:0] RELEASE_RST = 24'd13230;
    localparam logic [LVL_W-1:0] LEVEL_RST   = 17'd26214;

    typedef enum logic [IDX_W-1:0] {
        CFG_ATTACK_LEN    = 3'd0,
        CFG_DECAY_LEN     = 3'd1,
        CFG_SUSTAIN_LEN   = 3'd2,
        CFG_RELEASE_LEN   = 3'd3,
        CFG_SUSTAIN_LEVEL = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_GAIN,
        ST_SCALE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ladsr_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W bits.
`timescale 1ns / 1ps
`default_nettype none

module ladsr_div (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ladsr_pkg::div_req_t  req,
    output ladsr_pkg::div_stat_t      stat
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [ladsr_pkg::DCNT_W-1:0]    cnt_reg;
    logic [ladsr_pkg::LEN_W-1:0]     rem_reg;
    logic [ladsr_pkg::QUO_W-1:0]     quo_reg;
    logic [ladsr_pkg::LEN_W-1:0]     dsr_reg;

    logic [ladsr_pkg::LEN_W:0]       trial;
    logic [ladsr_pkg::LEN_W+1:0]     diff;
    logic                            fits;

    assign trial = {rem_reg, quo_reg[ladsr_pkg::QUO_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign fits  = ~diff[ladsr_pkg::LEN_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ladsr_pkg::DCNT_W'(ladsr_pkg::QUO_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ladsr_pkg::DCNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.dividend[ladsr_pkg::DVD_W-1:ladsr_pkg::QUO_W];
            quo_reg <= req.dividend[ladsr_pkg::QUO_W-1:0];
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[ladsr_pkg::LEN_W-1:0] : trial[ladsr_pkg::LEN_W-1:0];
            quo_reg <= {quo_reg[ladsr_pkg::QUO_W-2:0], fits};
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

    a_busy_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg && !done_reg)
        else $error("divider did not start");

    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !req.start && cnt_reg == ladsr_pkg::DCNT_W'(1) |=> done_reg)
        else $error("divider did not finish after last step");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= ladsr_pkg::DCNT_W'(ladsr_pkg::QUO_W))
        else $error("divider step count out of range");

endmodule

`default_nettype wire

// ===== hdl/linear_adsr_envelope.sv =====
// Linear ADSR envelope: scales each audio item by a sample-count-driven gain.
//
// Input channel s_*: one audio sample plus a restart flag per item. Result channel
// m_*: the scaled sample and the envelope phase (0 attack .. 4 finished), one
// result per input item, in order. Both channels use valid/ready.
// Config port: cfg_we writes cfg_data into register cfg_index (0 attack_len,
// 1 decay_len, 2 sustain_len, 3 release_len, 4 sustain_level); other indexes are
// ignored. Write only while no item is in flight.
// One item at a time: a small sequencer walks the phase boundaries (one add and
// compare per cycle, up to four); in attack, decay and release one shared
// multiplier forms the ramp numerator and a restoring divider produces the
// 17-bit gain quotient, and the same multiplier then scales the sample. s_ready
// is high only when the sequencer is idle, so a new item is taken only once the
// previous one has reached the output register.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following item waits in its last step
// until the output register frees.
// Reset restores the register defaults, clears the sample counter and drops
// any pending result.
`timescale 1ns / 1ps
`default_nettype none

module linear_adsr_envelope (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [ladsr_pkg::SAMPLE_WIDTH-1:0] s_in_sample,
    input  wire logic                                 s_restart,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [ladsr_pkg::SAMPLE_WIDTH-1:0] m_out_sample,
    output logic [2:0]                                m_phase,
    input  wire logic                                 cfg_we,
    input  wire logic [ladsr_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [ladsr_pkg::CFG_W-1:0]          cfg_data
);

    localparam int SW = ladsr_pkg::SAMPLE_WIDTH;

    ladsr_pkg::state_t state_reg, state_next;
    ladsr_pkg::phase_t phase_reg, phase_inc;

    logic [ladsr_pkg::LEN_W-1:0]       attack_len_reg;
    logic [ladsr_pkg::LEN_W-1:0]       decay_len_reg;
    logic [ladsr_pkg::LEN_W-1:0]       sustain_len_reg;
    logic [ladsr_pkg::LEN_W-1:0]       release_len_reg;
    logic [ladsr_pkg::LVL_W-1:0]       sustain_level_reg;

    logic [ladsr_pkg::COUNT_WIDTH-1:0] count_reg;
    logic signed [SW-1:0]              x_reg;
    logic [ladsr_pkg::BND_W-1:0]       base_reg;
    logic [ladsr_pkg::BND_W-1:0]       bnd_reg;
    logic [ladsr_pkg::GAIN_W-1:0]      gain_reg;
    logic signed [ladsr_pkg::PROD_W-1:0] prod_reg;

    logic                              m_valid_reg;
    logic signed [SW-1:0]              m_out_sample_reg;
    logic [2:0]                        m_phase_reg;

    logic [ladsr_pkg::CMP_W-1:0]       n_cmp;
    logic [ladsr_pkg::CMP_W-1:0]       bnd_cmp;
    logic [ladsr_pkg::CMP_W-1:0]       k_full;
    logic [ladsr_pkg::LEN_W-1:0]       k_val;
    logic                              found;
    logic [ladsr_pkg::LEN_W-1:0]       len_next;
    logic                              lv_above;
    logic [ladsr_pkg::GAIN_W-1:0]      ramp_m;
    logic [ladsr_pkg::LEN_W-1:0]       ramp_d;
    logic [ladsr_pkg::GAIN_W-1:0]      gain_next;

    logic signed [ladsr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ladsr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ladsr_pkg::PROD_W-1:0]  mul_p;

    logic [ladsr_pkg::SH_W-1:0]        shifted;
    logic [ladsr_pkg::SH_W-SW:0]       upper;
    logic [SW-1:0]                     sat_val;

    logic                              s_accept;
    logic                              out_free;
    logic                              count_max;

    ladsr_pkg::div_req_t               div_req;
    ladsr_pkg::div_stat_t              div_stat;

    ladsr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat)
    );

    assign s_ready      = (state_reg == ladsr_pkg::ST_IDLE);
    assign s_accept     = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign count_max    = &count_reg;
    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_out_sample_reg;
    assign m_phase      = m_phase_reg;

    // phase boundary walk
    assign n_cmp   = {{(ladsr_pkg::CMP_W-ladsr_pkg::COUNT_WIDTH){1'b0}}, count_reg};
    assign bnd_cmp = {{(ladsr_pkg::CMP_W-ladsr_pkg::BND_W){1'b0}}, bnd_reg};
    assign found   = n_cmp < bnd_cmp;
    assign k_full  = n_cmp - {{(ladsr_pkg::CMP_W-ladsr_pkg::BND_W){1'b0}}, base_reg};
    assign k_val   = k_full[ladsr_pkg::LEN_W-1:0];
    assign lv_above = sustain_level_reg > ladsr_pkg::UNITY;
    assign phase_inc = ladsr_pkg::phase_t'(3'(phase_reg + 3'd1));

    always_comb begin
        len_next = '0;
        ramp_m   = ladsr_pkg::UNITY;
        ramp_d   = attack_len_reg;
        case (phase_reg)
            ladsr_pkg::PH_ATTACK: begin
                len_next = decay_len_reg;
            end
            ladsr_pkg::PH_DECAY: begin
                len_next = sustain_len_reg;
                ramp_m   = lv_above ? (sustain_level_reg - ladsr_pkg::UNITY)
                                    : (ladsr_pkg::UNITY - sustain_level_reg);
                ramp_d   = decay_len_reg;
            end
            ladsr_pkg::PH_SUSTAIN: begin
                len_next = release_len_reg;
            end
            ladsr_pkg::PH_RELEASE: begin
                ramp_m = sustain_level_reg;
                ramp_d = release_len_reg;
            end
            default: begin
                len_next = '0;
            end
        endcase
    end

    always_comb begin
        case (phase_reg)
            ladsr_pkg::PH_ATTACK:  gain_next = div_stat.quotient;
            ladsr_pkg::PH_DECAY:   gain_next = lv_above
                                       ? (ladsr_pkg::UNITY + div_stat.quotient)
                                       : (ladsr_pkg::UNITY - div_stat.quotient);
            ladsr_pkg::PH_SUSTAIN: gain_next = sustain_level_reg;
            ladsr_pkg::PH_RELEASE: gain_next = sustain_level_reg - div_stat.quotient;
            default:               gain_next = '0;
        endcase
    end

    // shared multiplier: ramp numerator, then sample scaling
    always_comb begin
        if (state_reg == ladsr_pkg::ST_SCALE) begin
            mul_a = {{(ladsr_pkg::MUL_A_W-SW){x_reg[SW-1]}}, x_reg};
            mul_b = {1'b0, gain_reg};
        end else begin
            mul_a = {{(ladsr_pkg::MUL_A_W-ladsr_pkg::LEN_W){1'b0}}, k_val};
            mul_b = {1'b0, ramp_m};
        end
    end
    assign mul_p = mul_a * mul_b;

    assign div_req.start    = (state_reg == ladsr_pkg::ST_DIV_GO);
    assign div_req.dividend = prod_reg[ladsr_pkg::DVD_W-1:0];
    assign div_req.divisor  = ramp_d;

    // floor shift and saturation
    assign shifted = prod_reg[ladsr_pkg::PROD_W-1:ladsr_pkg::FRAC_W];
    assign upper   = shifted[ladsr_pkg::SH_W-1:SW-1];
    assign sat_val = ((&upper) || !(|upper)) ? shifted[SW-1:0]
                   : (shifted[ladsr_pkg::SH_W-1] ? {1'b1, {(SW-1){1'b0}}}
                                                 : {1'b0, {(SW-1){1'b1}}});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ladsr_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = ladsr_pkg::ST_FIND;
                end
            end
            ladsr_pkg::ST_FIND: begin
                if (found) begin
                    state_next = (phase_reg == ladsr_pkg::PH_SUSTAIN)
                               ? ladsr_pkg::ST_GAIN : ladsr_pkg::ST_MUL;
                end else if (phase_reg == ladsr_pkg::PH_RELEASE) begin
                    state_next = ladsr_pkg::ST_GAIN;
                end
            end
            ladsr_pkg::ST_MUL:    state_next = ladsr_pkg::ST_DIV_GO;
            ladsr_pkg::ST_DIV_GO: state_next = ladsr_pkg::ST_DIV_WAIT;
            ladsr_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = ladsr_pkg::ST_GAIN;
                end
            end
            ladsr_pkg::ST_GAIN:  state_next = ladsr_pkg::ST_SCALE;
            ladsr_pkg::ST_SCALE: state_next = ladsr_pkg::ST_OUT;
            ladsr_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = ladsr_pkg::ST_IDLE;
                end
            end
            default: state_next = ladsr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ladsr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control state: config, counter, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_len_reg    <= ladsr_pkg::ATTACK_RST;
            decay_len_reg     <= ladsr_pkg::DECAY_RST;
            sustain_len_reg   <= ladsr_pkg::SUSTAIN_RST;
            release_len_reg   <= ladsr_pkg::RELEASE_RST;
            sustain_level_reg <= ladsr_pkg::LEVEL_RST;
            count_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    ladsr_pkg::CFG_ATTACK_LEN:    attack_len_reg  <= cfg_data;
                    ladsr_pkg::CFG_DECAY_LEN:     decay_len_reg   <= cfg_data;
                    ladsr_pkg::CFG_SUSTAIN_LEN:   sustain_len_reg <= cfg_data;
                    ladsr_pkg::CFG_RELEASE_LEN:   release_len_reg <= cfg_data;
                    ladsr_pkg::CFG_SUSTAIN_LEVEL:
                        sustain_level_reg <= cfg_data[ladsr_pkg::LVL_W-1:0];
                    default: ;
                endcase
            end
            if (s_accept && s_restart) begin
                count_reg <= '0;
            end else if (state_reg == ladsr_pkg::ST_OUT && out_free && !count_max) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == ladsr_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg     <= s_in_sample;
            phase_reg <= ladsr_pkg::PH_ATTACK;
            base_reg  <= '0;
            bnd_reg   <= {2'b00, attack_len_reg};
        end
        if (state_reg == ladsr_pkg::ST_FIND && !found) begin
            if (phase_reg == ladsr_pkg::PH_RELEASE) begin
                phase_reg <= ladsr_pkg::PH_DONE;
            end else begin
                phase_reg <= phase_inc;
                base_reg  <= bnd_reg;
                bnd_reg   <= bnd_reg + {2'b00, len_next};
            end
        end
        if (state_reg == ladsr_pkg::ST_MUL || state_reg == ladsr_pkg::ST_SCALE) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ladsr_pkg::ST_GAIN) begin
            gain_reg <= gain_next;
        end
        if (state_reg == ladsr_pkg::ST_OUT && out_free) begin
            m_out_sample_reg <= sat_val;
            m_phase_reg      <= phase_reg;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_sample) && $stable(m_phase))
        else $error("result changed while waiting");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_phase <= ladsr_pkg::PH_DONE)
        else $error("result phase out of range");

    a_restart_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_restart |=> count_reg == '0)
        else $error("restart did not clear sample counter");

endmodule

`default_nettype wire

// ===== dv/envelope_checker.sv =====
// Envelope checker: mirrors registers and sample counter, predicts each result, compares.
`timescale 1ns / 1ps

module envelope_checker
    import ladsr_pkg::*;
(
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_in_sample,
    input  wire logic                           s_restart,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] m_out_sample,
    input  wire logic [2:0]                     m_phase,
    input  wire logic                           cfg_we,
    input  wire logic [IDX_W-1:0]               cfg_index,
    input  wire logic [CFG_W-1:0]               cfg_data,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        phase_t                         phase;
    } scaled_t;

    localparam logic [COUNT_WIDTH-1:0] POS_MAX = '1;
    localparam longint OUT_HI = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint OUT_LO = -OUT_HI - 1;

    logic [LEN_W-1:0]       atk_len;
    logic [LEN_W-1:0]       dec_len;
    logic [LEN_W-1:0]       sus_len;
    logic [LEN_W-1:0]       rel_len;
    logic [LVL_W-1:0]       sus_lvl;
    logic [COUNT_WIDTH-1:0] note_pos;
    scaled_t                scaled_q[$];

    function automatic scaled_t envelope_scale(input logic signed [SAMPLE_WIDTH-1:0] smp,
                                               input longint unsigned n);
        longint unsigned a, da, su, re, lv, g;
        longint          prod, y;
        scaled_t         r;
        a  = atk_len;
        da = a + dec_len;
        su = da + sus_len;
        re = su + rel_len;
        lv = sus_lvl;
        if (n < a) begin
            r.phase = PH_ATTACK;
            g = (n * UNITY) / a;
        end else if (n < da) begin
            r.phase = PH_DECAY;
            if (lv <= UNITY) begin
                g = UNITY - ((UNITY - lv) * (n - a)) / dec_len;
            end else begin
                g = UNITY + ((lv - UNITY) * (n - a)) / dec_len;
            end
        end else if (n < su) begin
            r.phase = PH_SUSTAIN;
            g = lv;
        end else if (n < re) begin
            r.phase = PH_RELEASE;
            g = lv - (lv * (n - su)) / rel_len;
        end else begin
            r.phase = PH_DONE;
            g = 0;
        end
        prod = longint'(smp) * longint'(g);
        y = prod >>> FRAC_W;
        if (y > OUT_HI) begin
            y = OUT_HI;
        end else if (y < OUT_LO) begin
            y = OUT_LO;
        end
        r.sample = y[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        scaled_t want;
        if (!aresetn) begin
            atk_len  = ATTACK_RST;
            dec_len  = DECAY_RST;
            sus_len  = SUSTAIN_RST;
            rel_len  = RELEASE_RST;
            sus_lvl  = LEVEL_RST;
            note_pos = '0;
            scaled_q.delete();
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ATTACK_LEN:    atk_len = cfg_data;
                    CFG_DECAY_LEN:     dec_len = cfg_data;
                    CFG_SUSTAIN_LEN:   sus_len = cfg_data;
                    CFG_RELEASE_LEN:   rel_len = cfg_data;
                    CFG_SUSTAIN_LEVEL: sus_lvl = cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_restart) note_pos = '0;
                scaled_q.push_back(envelope_scale(s_in_sample, note_pos));
                if (note_pos != POS_MAX) note_pos = note_pos + 1'b1;
            end
            if (m_valid && m_ready) begin
                if (scaled_q.size() == 0) begin
                    $error("unexpected item: out_sample %0d phase %0d", m_out_sample, m_phase);
                    fail_count++;
                end else begin
                    want = scaled_q.pop_front();
                    if (m_out_sample !== want.sample) begin
                        $error("out_sample: expected %0d, got %0d", want.sample, m_out_sample);
                        fail_count++;
                    end
                    if (m_phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, m_phase);
                        fail_count++;
                    end
                end
            end
            pending <= scaled_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top: directed and random stimulus for linear_adsr_envelope, verdict from envelope_checker.
`timescale 1ns / 1ps

module testbench;

    import ladsr_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int ITEM_GOAL    = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int NOTE_CAP     = 300;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_valid     = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] s_in_sample = '0;
    logic                           s_restart   = 1'b0;
    logic                           m_ready     = 1'b0;
    logic                           cfg_we      = 1'b0;
    logic [IDX_W-1:0]               cfg_index   = '0;
    logic [CFG_W-1:0]               cfg_data    = '0;
    logic                           s_ready;
    logic                           m_valid;
    logic signed [SAMPLE_WIDTH-1:0] m_out_sample;
    logic [2:0]                     m_phase;

    int fail_count;
    int pending;
    int tx_max   = 18;
    int rx_max   = 18;
    int rx_stall = 0;
    int quiet    = 0;

    logic signed [SAMPLE_WIDTH-1:0] corner_samples [7] = '{
        24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h555555, 24'hAAAAAA
    };

    linear_adsr_envelope DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_sample  (s_in_sample),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample),
        .m_phase      (m_phase),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    envelope_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_sample  (s_in_sample),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample),
        .m_phase      (m_phase),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int draw_wait(input int cap);
        return (cap == 0) ? 0 : $urandom_range(0, cap);
    endfunction

    function automatic int pick_cap();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 4;
            default: return 18;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '1;
        if (r == 1) return LEN_W'($urandom);
        if (r <= 4) return '0;
        return LEN_W'($urandom_range(1, 40));
    endfunction

    function automatic logic [LVL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return UNITY;
            2:       return '1;
            3:       return LVL_W'($urandom_range(UNITY + 1, 17'h1FFFF));
            default: return LVL_W'($urandom_range(0, UNITY));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        if ($urandom_range(0, 9) < 2) return corner_samples[$urandom_range(0, 6)];
        return SAMPLE_WIDTH'($urandom);
    endfunction

    // receiver: stalls a drawn number of cycles after each result
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            rx_stall = draw_wait(rx_max);
            if (rx_stall != 0) m_ready <= 1'b0;
        end else if (!m_ready) begin
            if (rx_stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                rx_stall--;
            end
        end
    end

    always @(posedge aclk) begin
        quiet <= ((s_valid && s_ready) || (m_valid && m_ready)) ? 0 : quiet + 1;
    end

    initial begin : watchdog
        wait (quiet >= QUIET_LIMIT);
        $display("linear_adsr_envelope test failed");
        $finish;
    end

    // valid stays up across back-to-back items; lowered only when a gap follows or the bench drains
    task automatic send_item(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic rst);
        int gap;
        gap = draw_wait(tx_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_sample <= smp;
        s_restart   <= rst;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
    endtask

    task automatic load_envelope(input logic [LEN_W-1:0] atk, input logic [LEN_W-1:0] dec,
                                 input logic [LEN_W-1:0] sus, input logic [LEN_W-1:0] rel,
                                 input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] junk;
        logic [CFG_W-1:0] word;
        junk = IDX_W'(CFG_SUSTAIN_LEVEL + $urandom_range(1, 3));
        word = CFG_W'($urandom);
        word[LVL_W-1:0] = lvl;
        wait_drained();
        write_reg(CFG_ATTACK_LEN, atk);
        write_reg(CFG_DECAY_LEN, dec);
        write_reg(CFG_SUSTAIN_LEN, sus);
        write_reg(junk, CFG_W'($urandom));
        write_reg(CFG_RELEASE_LEN, rel);
        write_reg(CFG_SUSTAIN_LEVEL, word);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] lens [4];
        int unsigned      span;
        int unsigned      note_len;
        int unsigned      left;
        int               items;
        int               sent;
        int               round;
        logic             rst;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults
        send_item(corner_samples[0], 1'b1);
        send_item(corner_samples[1], 1'b0);
        send_item(pick_sample(), 1'b0);

        // short phases: walk attack, decay, sustain, release, finished
        load_envelope(4, 4, 3, 4, 17'd32768);
        for (int i = 0; i < 17; i++) send_item(corner_samples[i % 7], i == 0);

        // no attack or release, sustain above unity: rising decay, saturation
        load_envelope(0, 3, 2, 0, 17'h1FFFF);
        for (int i = 0; i < 6; i++) send_item(corner_samples[i % 2], i == 0);

        sent  = 0;
        round = 0;
        while (sent < ITEM_GOAL) begin
            if (round == 0) begin
                foreach (lens[k]) lens[k] = '0;
                load_envelope(lens[0], lens[1], lens[2], lens[3], UNITY);
            end else if (round == 1) begin
                foreach (lens[k]) lens[k] = '1;
                load_envelope(lens[0], lens[1], lens[2], lens[3], '1);
            end else begin
                foreach (lens[k]) lens[k] = pick_len();
                load_envelope(lens[0], lens[1], lens[2], lens[3], pick_level());
            end
            tx_max   = pick_cap();
            rx_max   = pick_cap();
            span     = lens[0] + lens[1] + lens[2] + lens[3];
            note_len = ((span > NOTE_CAP) ? NOTE_CAP : span) + $urandom_range(1, 6);
            items    = $urandom_range(80, 260);
            left     = 0;
            repeat (items) begin
                if (left == 0) begin
                    rst  = 1'b1;
                    left = note_len;
                end else begin
                    rst = ($urandom_range(0, 39) == 0);
                end
                left--;
                send_item(pick_sample(), rst);
                sent++;
            end
            round++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("linear_adsr_envelope test passed");
        end else begin
            $display("linear_adsr_envelope test failed");
        end
        $finish;
    end

endmodule
